// ===== rtl/core/pcm_capture_gain_clip_meter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// PCM capture assertion macros
// Short forms for the concurrent checks of the capture block.
// ----------------------------------------------------------------------------
`ifndef PCM_CAPTURE_GAIN_CLIP_METER_UNIT_MACROS_SVH
`define PCM_CAPTURE_GAIN_CLIP_METER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define PCGCM_ASSERT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define PCGCM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pcgcm_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM capture package
// Types, constants and helper functions shared by the capture block.
// ----------------------------------------------------------------------------
package pcgcm_pkg;

	localparam int MAX_CHANNELS = 6;
	localparam int IN_WORDS     = 6;
	localparam int CH_W         = 3;
	localparam int RAW_W        = 32;
	localparam int GAIN_W       = 24;
	localparam int CFG_W        = 24;
	localparam int IDX_W        = 3;
	localparam int SMP_W        = 35;  // signed downmix sum
	localparam int ABS_W        = 34;
	localparam int PROD_W       = ABS_W + GAIN_W;
	localparam int NORM_SHIFT   = 6;
	localparam int NUM_W        = PROD_W + NORM_SHIFT;
	localparam int QUO_W        = NUM_W / 2;
	localparam int DEN_W        = 34;
	localparam int PEAK_W       = 31;
	localparam int SAMPLE_W     = 24;
	localparam int CLIPCNT_W    = 2;

	localparam int DIV_STEPS    = 4;
	localparam int DIV_CYCLES   = QUO_W / DIV_STEPS;
	localparam int CNT_W        = $clog2(DIV_CYCLES + 3);
	localparam logic [CNT_W-1:0] CNT_MUL = CNT_W'(DIV_CYCLES + 2);
	localparam logic [CNT_W-1:0] CNT_PRE = CNT_W'(DIV_CYCLES + 1);
	localparam logic [CNT_W-1:0] CNT_DIV = CNT_W'(DIV_CYCLES);

	localparam logic [QUO_W-1:0]  ONE_Q22     = QUO_W'(4194304);
	localparam logic [QUO_W-1:0]  PEAK_MAX    = QUO_W'(2147483647);
	localparam logic signed [SAMPLE_W-1:0] ONE_SAMPLE = 24'sd4194304;
	localparam logic [CLIPCNT_W-1:0] CLIP_FULL = 2'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH_CODE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_IN_CHANNELS  = 3'd1;
	localparam logic [IDX_W-1:0] REG_OUT_CHANNELS = 3'd2;
	localparam logic [IDX_W-1:0] REG_DOWNMIX      = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN         = 3'd4;

	// sample width codes
	localparam logic [1:0] WIDTH_8  = 2'd0;
	localparam logic [1:0] WIDTH_16 = 2'd1;
	localparam logic [1:0] WIDTH_24 = 2'd2;
	localparam logic [1:0] WIDTH_32 = 2'd3;

	typedef struct packed {
		logic [RAW_W-1:0] raw_0;
		logic [RAW_W-1:0] raw_1;
		logic [RAW_W-1:0] raw_2;
		logic [RAW_W-1:0] raw_3;
		logic [RAW_W-1:0] raw_4;
		logic [RAW_W-1:0] raw_5;
		logic             fragment_end;
	} in_t;

	typedef struct packed {
		logic [CH_W-1:0]            out_channel;
		logic signed [SAMPLE_W-1:0] out_sample;
		logic                       clipped;
		logic [PEAK_W-1:0]          peak;
		logic                       over_flag;
		logic                       frame_last;
	} out_t;

	// what one lane hands to the merge stage
	typedef struct packed {
		logic             neg;
		logic [QUO_W-1:0] mag;  // all ones when the quotient overflowed
	} lane_res_t;

	function automatic logic signed [RAW_W-1:0] sext(input logic [RAW_W-1:0] raw,
			input logic [1:0] wc);
		logic signed [RAW_W-1:0] v;
		case (wc)
			WIDTH_8:  v = RAW_W'($signed(raw[7:0]));
			WIDTH_16: v = RAW_W'($signed(raw[15:0]));
			WIDTH_24: v = RAW_W'($signed(raw[23:0]));
			default:  v = $signed(raw);
		endcase
		return v;
	endfunction

	function automatic logic [CH_W-1:0] clamp_chan(input logic [CH_W-1:0] n);
		return (n > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : n;
	endfunction

	// ch mod n for small counts, n nonzero
	function automatic logic [CH_W-1:0] src_chan(input logic [CH_W-1:0] ch,
			input logic [CH_W-1:0] n);
		logic [CH_W-1:0] r;
		r = ch;
		for (int k = 0; k < MAX_CHANNELS - 1; k++) begin
			if (r >= n)
				r = r - n;
		end
		return r;
	endfunction

	function automatic logic [DEN_W-1:0] den_of(input logic [1:0] wc, input logic mix);
		logic [DEN_W-1:0] b;
		case (wc)
			WIDTH_8:  b = DEN_W'(127);
			WIDTH_16: b = DEN_W'(32767);
			WIDTH_24: b = DEN_W'(8388607);
			default:  b = DEN_W'(2147483647);
		endcase
		return mix ? ((b << 2) + b) : b;
	endfunction

endpackage

// ===== rtl/core/pcgcm_lane.sv =====
// ----------------------------------------------------------------------------
// PCM capture lane
// Scales one channel: |S| * gain, then a radix-16 restoring divide by the
// full-scale denominator with rounding, saturated past 32 quotient bits.
// ----------------------------------------------------------------------------
module pcgcm_lane
	import pcgcm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SMP_W-1:0] s,
	input  logic [GAIN_W-1:0]       gain,
	input  logic [DEN_W-1:0]        den,
	output lane_res_t               res,
	output logic                    rdy
);

	logic [CNT_W-1:0]  cnt_q;
	logic              rdy_q;
	logic [ABS_W-1:0]  abs_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_q;
	logic              sat_q;
	logic [DEN_W-1:0]  rem_q;
	logic [QUO_W-1:0]  lo_q;
	logic [QUO_W-1:0]  quot_q;

	logic [SMP_W-1:0]  s_abs;
	logic [NUM_W-1:0]  num;
	logic [QUO_W-1:0]  num_hi;
	logic [DEN_W-1:0]  rem_n;
	logic [QUO_W-1:0]  lo_n;
	logic [QUO_W-1:0]  quo_n;
	logic [DEN_W:0]    trial;
	logic              div_on;

	assign s_abs  = s[SMP_W-1] ? SMP_W'(-s) : SMP_W'(s);
	assign num    = {prod_q, NORM_SHIFT'(0)} + NUM_W'(den >> 1);
	assign num_hi = num[NUM_W-1 -: QUO_W];
	assign div_on = (cnt_q != '0) && (cnt_q <= CNT_DIV);

	always_comb begin
		rem_n = rem_q;
		lo_n  = lo_q;
		quo_n = quot_q;
		trial = '0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial = {rem_n, lo_n[QUO_W-1]};
			lo_n  = {lo_n[QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				rem_n = DEN_W'(trial - {1'b0, den});
				quo_n = {quo_n[QUO_W-2:0], 1'b1};
			end else begin
				rem_n = trial[DEN_W-1:0];
				quo_n = {quo_n[QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rdy_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CNT_MUL;
			rdy_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				rdy_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			abs_q <= s_abs[ABS_W-1:0];
			neg_q <= s[SMP_W-1];
		end
		if (cnt_q == CNT_MUL)
			prod_q <= abs_q * gain;
		if (cnt_q == CNT_PRE) begin
			// quotient of 2^32 or more can only saturate
			sat_q  <= {(DEN_W - QUO_W)'(0), num_hi} >= den;
			rem_q  <= {(DEN_W - QUO_W)'(0), num_hi};
			lo_q   <= num[QUO_W-1:0];
			quot_q <= '0;
		end
		if (div_on) begin
			rem_q  <= rem_n;
			lo_q   <= lo_n;
			quot_q <= quo_n;
		end
	end

	assign res.neg = neg_q;
	assign res.mag = sat_q ? '1 : quot_q;
	assign rdy     = rdy_q;

endmodule

// ===== rtl/core/pcgcm_merge.sv =====
// ----------------------------------------------------------------------------
// PCM capture merge stage
// Clips lane results, updates the peak meter and clip counters, and plays
// the frame's results out one per transaction.
// ----------------------------------------------------------------------------
module pcgcm_merge
	import pcgcm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            frag_end,
	input  logic [CH_W-1:0] n_out,
	input  lane_res_t       res [MAX_CHANNELS],
	output logic            bank_free,
	output logic            out_valid,
	input  logic            out_stall,
	output out_t            out_data
);

	logic [PEAK_W-1:0]    peak_q [MAX_CHANNELS];
	logic [CLIPCNT_W-1:0] clip_q [MAX_CHANNELS];
	out_t                 bank_q [MAX_CHANNELS];
	logic [CH_W-1:0]      left_q;

	out_t                 row    [MAX_CHANNELS];
	logic [PEAK_W-1:0]    peak_n [MAX_CHANNELS];
	logic [CLIPCNT_W-1:0] clip_n [MAX_CHANNELS];

	logic                 out_acc;

	always_comb begin
		for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
			logic                clip;
			logic [QUO_W-1:0]    cmag;
			logic [PEAK_W-1:0]   msat;
			clip = res[ch].mag > ONE_Q22;
			cmag = clip ? ONE_Q22 : res[ch].mag;
			msat = (res[ch].mag > PEAK_MAX) ? PEAK_MAX[PEAK_W-1:0] : res[ch].mag[PEAK_W-1:0];
			peak_n[ch] = (msat > peak_q[ch]) ? msat : peak_q[ch];
			clip_n[ch] = (clip && clip_q[ch] != CLIP_FULL) ? clip_q[ch] + 1'b1 : clip_q[ch];
			row[ch].out_channel = CH_W'(ch);
			row[ch].out_sample  = res[ch].neg ? SAMPLE_W'(-cmag) : SAMPLE_W'(cmag);
			row[ch].clipped     = clip;
			row[ch].peak        = peak_n[ch];
			row[ch].over_flag   = frag_end && (clip_n[ch] == CLIP_FULL);
			row[ch].frame_last  = (CH_W'(ch) == n_out - 1'b1);
		end
	end

	assign bank_free = (left_q == '0);
	assign out_valid = (left_q != '0);
	assign out_acc   = out_valid && !out_stall;
	assign out_data  = bank_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				peak_q[ch] <= '0;
				clip_q[ch] <= '0;
			end
		end else if (load) begin
			left_q <= n_out;
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				if (CH_W'(ch) < n_out) begin
					peak_q[ch] <= frag_end ? '0 : peak_n[ch];
					clip_q[ch] <= frag_end ? '0 : clip_n[ch];
				end
			end
		end else if (out_acc) begin
			left_q <= left_q - 1'b1;
		end
	end

	// result bank shifts toward the output slot
	always_ff @(posedge clk) begin
		if (load) begin
			bank_q <= row;
		end else if (out_acc) begin
			for (int i = 0; i < MAX_CHANNELS - 1; i++)
				bank_q[i] <= bank_q[i + 1];
		end
	end

endmodule

// ===== rtl/core/pcm_capture_gain_clip_meter_unit.sv =====
// ----------------------------------------------------------------------------
// PCM capture gain, clip and peak meter
// Normalizes a captured frame per output channel with gain, clipping and
// per-channel peak / clip-count metering over a fragment.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one transaction is one frame of six raw words and a
//   fragment_end mark. out channel: one transaction per output channel, in
//   channel order, frame_last on the last one of the frame.
//   cfg port: write register index/data with cfg_we; only while idle.
// Flow: the six lanes run in parallel; each does a multiply step, a setup
//   step and the radix-16 divide steps, then the frame loads into the result
//   bank, from which the first result is offered. The next frame is taken
//   the cycle after that load, so without output stalls the frame rate does
//   not depend on the output count.
// Stall: the result bank holds its head while out_stall is high; lanes may
//   finish the next frame meanwhile and wait until the bank drains.
// Reset: registers return to 16-bit, two in, two out, no downmix, unity
//   gain; peak meter and clip counts clear; no results pending.
// ----------------------------------------------------------------------------
`include "pcm_capture_gain_clip_meter_unit_macros.svh"

module pcm_capture_gain_clip_meter_unit
	import pcgcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [1:0]        width_code_q;
	logic [CH_W-1:0]   in_channels_q;
	logic [CH_W-1:0]   out_count_q;
	logic              downmix_q;
	logic [GAIN_W-1:0] gain_q;

	logic              busy_q;
	logic              frag_q;

	logic [CH_W-1:0]   n_in;
	logic [CH_W-1:0]   n_out;
	logic              mix;
	logic [DEN_W-1:0]  den;
	logic              in_acc;
	logic              load;
	logic              bank_free;

	logic [RAW_W-1:0]        raw [IN_WORDS];
	logic signed [RAW_W-1:0] smp [IN_WORDS];
	logic signed [SMP_W-1:0] lane_s   [MAX_CHANNELS];
	lane_res_t               lane_res [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] lane_rdy;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_code_q  <= WIDTH_16;
			in_channels_q <= CH_W'(2);
			out_count_q   <= CH_W'(2);
			downmix_q     <= 1'b0;
			gain_q        <= GAIN_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH_CODE:   width_code_q  <= cfg_data[1:0];
				REG_IN_CHANNELS:  in_channels_q <= cfg_data[CH_W-1:0];
				REG_OUT_CHANNELS: out_count_q   <= cfg_data[CH_W-1:0];
				REG_DOWNMIX:      downmix_q     <= cfg_data[0];
				REG_GAIN:         gain_q        <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_in  = (in_channels_q == '0) ? CH_W'(1) : clamp_chan(in_channels_q);
	assign n_out = clamp_chan(out_count_q);
	assign mix   = downmix_q && (n_out == CH_W'(2)) && (n_in == CH_W'(6));
	assign den   = den_of(width_code_q, mix);

	assign raw[0] = in_data.raw_0;
	assign raw[1] = in_data.raw_1;
	assign raw[2] = in_data.raw_2;
	assign raw[3] = in_data.raw_3;
	assign raw[4] = in_data.raw_4;
	assign raw[5] = in_data.raw_5;

	always_comb begin
		for (int i = 0; i < IN_WORDS; i++)
			smp[i] = sext(raw[i], width_code_q);
	end

	// control: one frame in the lanes at a time
	assign in_stall = busy_q;
	assign in_acc   = in_valid && !in_stall;
	assign load     = busy_q && lane_rdy[0] && bank_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (in_acc)
			busy_q <= 1'b1;
		else if (load)
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			frag_q <= in_data.fragment_end;
	end

	for (genvar l = 0; l < MAX_CHANNELS; l++) begin : g_lane
		logic signed [SMP_W-1:0] plain;
		assign plain = SMP_W'(smp[src_chan(CH_W'(l), n_in)]);

		if (l < 2) begin : g_mix
			logic signed [SMP_W-1:0] msum;
			assign msum = SMP_W'(smp[0]) + (SMP_W'(smp[1 + l]) <<< 1)
				+ (SMP_W'(smp[3 + l]) <<< 1) + SMP_W'(smp[5]);
			assign lane_s[l] = mix ? msum : plain;
		end else begin : g_plain
			assign lane_s[l] = plain;
		end

		pcgcm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (in_acc),
			.s      (lane_s[l]),
			.gain   (gain_q),
			.den    (den),
			.res    (lane_res[l]),
			.rdy    (lane_rdy[l])
		);
	end

	pcgcm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.frag_end  (frag_q),
		.n_out     (n_out),
		.res       (lane_res),
		.bank_free (bank_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`PCGCM_ASSERT(a_lanes_lockstep, clk, arst_n, 1'b1, (lane_rdy == '0) || (lane_rdy == '1), "lanes out of step")
	`PCGCM_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && !in_stall, in_stall && (lane_rdy == '0), "accepted frame did not start lanes")
	`PCGCM_ASSERT(a_chan_range, clk, arst_n, out_valid, out_data.out_channel < n_out, "result channel beyond output count")
	`PCGCM_ASSERT(a_clip_bound, clk, arst_n, out_valid, (out_data.out_sample <= ONE_SAMPLE) && (out_data.out_sample >= -ONE_SAMPLE), "sample beyond full scale")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCM capture gain, clip and peak meter testbench
// Drives captured frames through the capture block under a series of register
// settings and checks every per-channel result against a cycle-free predictor
// of the gain, clipping, downmix and fragment peak/clip metering.
// ----------------------------------------------------------------------------
module tb_top;
	import pcgcm_pkg::*;

	localparam int          TOTAL_FRAMES = 370;
	localparam int          SETTLE       = 40;    // covers a frame that yields no result
	localparam int          WATCHDOG     = 2000;
	localparam logic [63:0] FULL_SCALE   = 64'd4194304;
	localparam logic [63:0] PEAK_CEIL    = 64'd2147483647;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b1;
	out_t             out_data;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// shadow of the register file, reset values
	logic [1:0]        sh_width = WIDTH_16;
	logic [2:0]        sh_nin = 3'd2;
	logic [2:0]        sh_nout = 3'd2;
	logic              sh_mix = 1'b0;
	logic [GAIN_W-1:0] sh_gain = 24'd65536;

	// meter state of the predictor
	logic [PEAK_W-1:0]    peak_acc [MAX_CHANNELS];
	logic [CLIPCNT_W-1:0] clip_tally [MAX_CHANNELS];

	in_t  frames_pending [$];
	out_t expected_results [$];

	int   in_offered = 0;
	int   in_taken = 0;
	int   gap_left = 0;
	int   results_seen = 0;
	int   results_noted = 0;
	int   stall_left = 0;
	int   idle_cycles = 0;
	int   bad_count = 0;
	int   frames_counted = 0;
	bit   in_idle_en = 1'b0;
	bit   out_idle_en = 1'b0;

	pcm_capture_gain_clip_meter_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			peak_acc[i] = '0;
			clip_tally[i] = '0;
		end
	end

	// expected per-channel results of one frame; updates the meter state
	function automatic void predict_channels(input in_t f);
		logic [31:0] w [6];
		longint      smp [6];
		longint      s;
		longint      span;
		logic [63:0] den, mag, q, r, m, cm, pk;
		int          bits, n_in, n_out;
		logic        neg, clip, mix;
		out_t        o;
		w[0] = f.raw_0;
		w[1] = f.raw_1;
		w[2] = f.raw_2;
		w[3] = f.raw_3;
		w[4] = f.raw_4;
		w[5] = f.raw_5;
		bits = 8 * (int'(sh_width) + 1);
		span = longint'(64'd1 << bits);
		for (int i = 0; i < 6; i++) begin
			smp[i] = longint'({32'd0, w[i]}) & (span - 1);
			if (smp[i] >= span / 2)
				smp[i] = smp[i] - span;
		end
		n_in = (sh_nin == 3'd0) ? 1 : ((sh_nin > 3'd6) ? 6 : int'(sh_nin));
		n_out = (sh_nout > 3'd6) ? 6 : int'(sh_nout);
		mix = sh_mix && n_out == 2 && n_in == 6;
		den = (64'd1 << (bits - 1)) - 64'd1;
		if (mix)
			den = den * 64'd5;
		for (int ch = 0; ch < n_out; ch++) begin
			if (mix)
				s = smp[0] + 2 * smp[1 + ch] + 2 * smp[3 + ch] + smp[5];
			else
				s = smp[ch % n_in];
			neg = s < 0;
			mag = neg ? 64'(-s) : 64'(s);
			mag = mag * {40'd0, sh_gain};
			q = mag / den;
			r = mag % den;
			m = q * 64'd64 + (r * 64'd64 + den / 64'd2) / den;
			clip = m > FULL_SCALE;
			cm = clip ? FULL_SCALE : m;
			pk = (m > PEAK_CEIL) ? PEAK_CEIL : m;
			if (pk > {33'd0, peak_acc[ch]})
				peak_acc[ch] = pk[PEAK_W-1:0];
			if (clip && clip_tally[ch] != CLIP_FULL)
				clip_tally[ch] = clip_tally[ch] + 2'd1;
			o.out_channel = CH_W'(ch);
			o.out_sample = neg ? -cm[SAMPLE_W-1:0] : cm[SAMPLE_W-1:0];
			o.clipped = clip;
			o.peak = peak_acc[ch];
			o.over_flag = f.fragment_end && clip_tally[ch] == CLIP_FULL;
			o.frame_last = (ch + 1 == n_out);
			expected_results.push_back(o);
			if (f.fragment_end) begin
				peak_acc[ch] = '0;
				clip_tally[ch] = '0;
			end
		end
	endfunction

	function automatic in_t pack_frame(input logic [31:0] a, b, c, d, e, g,
			input logic fe);
		in_t f;
		f.raw_0 = a;
		f.raw_1 = b;
		f.raw_2 = c;
		f.raw_3 = d;
		f.raw_4 = e;
		f.raw_5 = g;
		f.fragment_end = fe;
		return f;
	endfunction

	// random words biased toward full scale and near zero at the current width
	function automatic in_t rand_frame(input logic fe);
		logic [31:0] w [6];
		logic [31:0] mask, pat;
		int          bits;
		bits = 8 * (int'(sh_width) + 1);
		mask = 32'((64'd1 << bits) - 64'd1);
		for (int i = 0; i < 6; i++) begin
			case ($urandom_range(0, 7))
				0: pat = 32'((64'd1 << (bits - 1)) - 64'd1);
				1: pat = 32'(64'd1 << (bits - 1));
				2: pat = 32'($urandom_range(0, 31)) - 32'd16;
				default: pat = $urandom;
			endcase
			w[i] = ($urandom & ~mask) | (pat & mask);
		end
		return pack_frame(w[0], w[1], w[2], w[3], w[4], w[5], fe);
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [1:0] wc, input logic [2:0] nin,
			input logic [2:0] nout, input logic mx, input logic [GAIN_W-1:0] g);
		write_reg(REG_WIDTH_CODE, CFG_W'(wc));
		write_reg(REG_IN_CHANNELS, CFG_W'(nin));
		write_reg(REG_OUT_CHANNELS, CFG_W'(nout));
		write_reg(REG_DOWNMIX, CFG_W'(mx));
		write_reg(REG_GAIN, g);
		sh_width = wc;
		sh_nin = nin;
		sh_nout = nout;
		sh_mix = mx;
		sh_gain = g;
	endtask

	// sender holds off until every expected result is back, then lets the block settle
	task automatic drain();
		@(posedge clk);
		while (frames_pending.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// fragments of well-formed length, with an occasional stray fragment end
	task automatic queue_fragments(input int n);
		int frag_left;
		logic fe;
		frag_left = $urandom_range(1, 10);
		for (int i = 0; i < n; i++) begin
			frag_left--;
			fe = (frag_left == 0) || ($urandom_range(0, 15) == 0);
			if (frag_left == 0)
				frag_left = $urandom_range(1, 10);
			frames_pending.push_back(rand_frame(fe));
		end
	endtask

	// input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken == in_offered) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (frames_pending.size() != 0) begin
				in_data <= frames_pending.pop_front();
				in_valid <= 1'b1;
				in_offered <= in_offered + 1;
				gap_left <= in_idle_en ? $urandom_range(0, 14) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall: a fresh hold-off drawn after every accepted result
	always @(negedge clk) begin
		int hold_n;
		if (results_seen != results_noted) begin
			results_noted <= results_seen;
			hold_n = out_idle_en ? $urandom_range(0, 14) : 0;
		end else begin
			hold_n = stall_left;
		end
		out_stall <= (hold_n != 0) || !arst_n;
		stall_left <= (hold_n != 0) ? hold_n - 1 : 0;
	end

	// monitor: predicts on accepted frames, checks accepted results
	always @(posedge clk) begin
		out_t exp_r;
		bit   took;
		if (arst_n) begin
			took = (in_valid && !in_stall) || (out_valid && !out_stall);
			idle_cycles <= took ? 0 : idle_cycles + 1;
			if (in_valid && !in_stall) begin
				predict_channels(in_data);
				in_taken <= in_taken + 1;
			end
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected result: ch=%0d smp=%0d", out_data.out_channel,
							out_data.out_sample);
				end else begin
					exp_r = expected_results.pop_front();
					if (out_data.out_channel !== exp_r.out_channel
							|| out_data.out_sample !== exp_r.out_sample
							|| out_data.clipped !== exp_r.clipped
							|| out_data.peak !== exp_r.peak
							|| out_data.over_flag !== exp_r.over_flag
							|| out_data.frame_last !== exp_r.frame_last) begin
						bad_count++;
						if (bad_count <= 10)
							$display(
								"result mismatch: exp ch=%0d smp=%0d clip=%0b peak=%0d",
								exp_r.out_channel, exp_r.out_sample, exp_r.clipped,
								exp_r.peak,
								" over=%0b last=%0b, got ch=%0d smp=%0d clip=%0b",
								exp_r.over_flag, exp_r.frame_last,
								out_data.out_channel, out_data.out_sample, out_data.clipped,
								" peak=%0d over=%0b last=%0b",
								out_data.peak, out_data.over_flag, out_data.frame_last);
					end
				end
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0]        wc;
		logic [2:0]        nin, nout;
		logic              mx;
		logic [GAIN_W-1:0] g;
		int                n;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: 16 bit, two in, two out, unity gain
		frames_pending.push_back(pack_frame(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
		frames_pending.push_back(pack_frame(32'hABCD7FFF, 32'h12348000, 32'h0, 32'h0,
			32'h0, 32'h0, 1'b0));
		frames_pending.push_back(pack_frame(32'hFFFFFFFF, 32'h00000001, 32'h0, 32'h0,
			32'h0, 32'h0, 1'b1));
		drain();

		// 8 bit downmix at maximum gain: clips on every frame, flagged at fragment end
		set_config(WIDTH_8, 3'd6, 3'd2, 1'b1, 24'hFFFFFF);
		frames_pending.push_back(pack_frame(32'hFFFFFF7F, 32'h0000007F, 32'h1234567F,
			32'h0000007F, 32'h8000007F, 32'h0000007F, 1'b0));
		frames_pending.push_back(pack_frame(32'h00000080, 32'hFFFFFF80, 32'h00000080,
			32'h00000080, 32'h00000080, 32'h00000080, 1'b0));
		frames_pending.push_back(pack_frame(32'h0000007F, 32'h00000080, 32'h0000007F,
			32'h00000080, 32'h0000007F, 32'h00000080, 1'b0));
		frames_pending.push_back(pack_frame(32'h0000007F, 32'h0000007F, 32'h0000007F,
			32'h0000007F, 32'h0000007F, 32'h0000007F, 1'b1));
		drain();

		// zero input count acts as one, output count above six saturates, zero gain
		set_config(WIDTH_32, 3'd0, 3'd7, 1'b0, 24'd0);
		frames_pending.push_back(pack_frame(32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h2,
			32'h3, 32'h4, 1'b0));
		frames_pending.push_back(pack_frame(32'h80000000, 32'h7FFFFFFF, 32'h1, 32'h2,
			32'h3, 32'h4, 1'b1));
		drain();

		// zero output channels: nothing comes back
		set_config(WIDTH_24, 3'd7, 3'd0, 1'b1, 24'd65536);
		frames_pending.push_back(pack_frame(32'h007FFFFF, 32'h00800000, 32'h0, 32'h0,
			32'h0, 32'h0, 1'b0));
		frames_pending.push_back(pack_frame(32'hFF7FFFFF, 32'h00800000, 32'h0, 32'h0,
			32'h0, 32'h0, 1'b1));
		drain();

		// downmix requested but three outputs: plain mapping
		set_config(WIDTH_32, 3'd6, 3'd3, 1'b1, 24'd65536);
		frames_pending.push_back(pack_frame(32'h7FFFFFFF, 32'h80000000, 32'h00000001,
			32'hFFFFFFFF, 32'h0, 32'h12345678, 1'b0));
		frames_pending.push_back(pack_frame(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
			32'h00000001, 32'h0, 32'hEDCBA988, 1'b0));
		frames_pending.push_back(pack_frame(32'h40000000, 32'hC0000000, 32'h0, 32'h0,
			32'h0, 32'h0, 1'b1));
		drain();

		// 24 bit at double gain, a two-frame fragment then a single-frame one
		set_config(WIDTH_24, 3'd3, 3'd6, 1'b0, 24'h020000);
		frames_pending.push_back(pack_frame(32'hAA7FFFFF, 32'h55800000, 32'h00400000,
			32'h0, 32'h0, 32'h0, 1'b0));
		frames_pending.push_back(pack_frame(32'h007FFFFF, 32'hFF800000, 32'h00C00000,
			32'h0, 32'h0, 32'h0, 1'b1));
		frames_pending.push_back(pack_frame(32'h00800000, 32'h007FFFFF, 32'h00000001,
			32'h0, 32'h0, 32'h0, 1'b1));
		drain();
		frames_counted = 17;

		while (frames_counted < TOTAL_FRAMES) begin
			wc = 2'($urandom_range(0, 3));
			nin = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 6));
			nout = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 6));
			mx = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0) begin
				nin = 3'd6;
				nout = 3'd2;
				mx = 1'b1;
			end
			case ($urandom_range(0, 7))
				0: g = 24'd0;
				1: g = 24'hFFFFFF;
				2: g = 24'd65536;
				3, 4, 5: g = GAIN_W'($urandom_range(0, 131072));
				default: g = GAIN_W'($urandom_range(0, 24'hFFFFFF));
			endcase
			set_config(wc, nin, nout, mx, g);
			in_idle_en = $urandom_range(0, 3) != 0;
			out_idle_en = $urandom_range(0, 3) != 0;
			n = $urandom_range(8, 30);
			queue_fragments(n);
			frames_counted += n;
			drain();
		end

		if (bad_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
